// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the band-pass biquad RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Check that a condition implies another in the cycle after it.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== hw/rtl/mbbg_pkg.sv =====
// Package with constants, types and rounding helpers of the band-pass biquad core.
`timescale 1ns / 1ps
`default_nettype none

package mbbg_pkg;

    localparam int CHANNEL_COUNT  = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 24;
    localparam int GAIN_BITS      = 23;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int CHAN_BITS      = 3;
    localparam int BYPASS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = (COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS;
    localparam int CH_IDX_BITS    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // x + x2 -/+ 2*x1 needs two extra bits
    localparam int FF_BITS    = SAMPLE_BITS + 2;
    localparam int MUL_A_BITS = FF_BITS;
    localparam int MUL_B_BITS = (COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS   = PROD_BITS + 2;

    localparam logic [GAIN_BITS-1:0]   GAIN_UNITY   = GAIN_BITS'(1 << GAIN_FRAC_BITS);
    localparam logic [BYPASS_BITS-1:0] BYPASS_RESET = '1;

    localparam logic signed [ACC_BITS-1:0] SAT_MAX =
        ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] SAT_MIN =
        ACC_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HP_B0,
        CFG_HP_A1,
        CFG_HP_A2,
        CFG_LP_B0,
        CFG_LP_A1,
        CFG_LP_A2,
        CFG_GAIN,
        CFG_BYPASS
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_HP_B,
        ST_HP_A1,
        ST_HP_A2,
        ST_HP_SUM,
        ST_HP_RND,
        ST_LP_FF,
        ST_LP_B,
        ST_LP_A1,
        ST_LP_A2,
        ST_LP_SUM,
        ST_LP_RND,
        ST_GAIN_M,
        ST_GAIN_RND,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {MUL_B0, MUL_A1, MUL_A2, MUL_GAIN} mul_sel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_SUB} acc_op_t;
    typedef enum logic [1:0] {STG_HOLD, STG_PASS, STG_RND} stg_op_t;
    typedef enum logic [1:0] {RES_HOLD, RES_ZERO, RES_GAIN} res_op_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] hp_b0;
        logic signed [COEF_BITS-1:0] hp_a1;
        logic signed [COEF_BITS-1:0] hp_a2;
        logic signed [COEF_BITS-1:0] lp_b0;
        logic signed [COEF_BITS-1:0] lp_a1;
        logic signed [COEF_BITS-1:0] lp_a2;
        logic [GAIN_BITS-1:0]        gain;
        logic [BYPASS_BITS-1:0]      bypass;
    } cfg_t;

    // one history entry per channel: last two inputs, middle and low-pass outputs
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [SAMPLE_BITS-1:0] m1;
        logic signed [SAMPLE_BITS-1:0] m2;
        logic signed [SAMPLE_BITS-1:0] l1;
        logic signed [SAMPLE_BITS-1:0] l2;
    } hist_t;

    typedef struct packed {
        logic     ff_load;
        logic     ff_lp;
        mul_sel_t mul_sel;
        logic     coef_lp;
        acc_op_t  acc_op;
        stg_op_t  hp_op;
        stg_op_t  lp_op;
        res_op_t  res_op;
    } ctrl_t;

    typedef struct packed {
        logic idle;
        logic out_load;
        logic hist_we;
    } seq_stat_t;

    // round to nearest with ties up, shift right, saturate to a sample
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_BITS-1:0] v,
        input int unsigned                sh
    );
        logic signed [ACC_BITS-1:0]    r;
        logic signed [SAMPLE_BITS-1:0] o;
        r = (v + (ACC_BITS'(1) <<< (sh - 1))) >>> sh;
        if (r > SAT_MAX) begin
            o = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (r < SAT_MIN) begin
            o = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            o = r[SAMPLE_BITS-1:0];
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbbg_hist_mem.sv =====
// Per-channel history memory with valid bits cleared at reset and on coefficient writes.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mbbg_hist_mem import mbbg_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rstn,
    input  wire logic                   clear,
    input  wire logic                   rd_en,
    input  wire logic [CH_IDX_BITS-1:0] rd_addr,
    output hist_t                       rd_data,
    input  wire logic                   wr_en,
    input  wire logic [CH_IDX_BITS-1:0] wr_addr,
    input  wire hist_t                  wr_data
);

    hist_t                     hist_mem [CHANNEL_COUNT];
    hist_t                     rd_data_reg;
    logic                      rd_valid_reg;
    logic [CHANNEL_COUNT-1:0]  valid_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // an entry never written since the last clear reads as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    `ASSERT_AT(a_no_rd_wr_overlap, clk, rstn, !(rd_en && wr_en))

endmodule

`default_nettype wire

// ===== hw/rtl/mbbg_dp.sv =====
// Datapath with the shared multiplier, accumulator, rounding and history update.
`timescale 1ns / 1ps
`default_nettype none

module mbbg_dp import mbbg_pkg::*; (
    input  wire logic                          clk,
    input  wire logic                          accept,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic [CHAN_BITS-1:0]          channel_in,
    input  wire ctrl_t                         ctrl,
    input  wire cfg_t                          cfg,
    input  wire hist_t                         hist,
    output logic signed [SAMPLE_BITS-1:0]      result,
    output logic [CHAN_BITS-1:0]               channel,
    output hist_t                              hist_wr
);

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [CHAN_BITS-1:0]          chan_reg;
    logic signed [FF_BITS-1:0]     ff_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [SAMPLE_BITS-1:0] hp_reg;
    logic signed [SAMPLE_BITS-1:0] lp_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;

    logic signed [FF_BITS-1:0]     ff_val;
    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [SAMPLE_BITS-1:0] y1_sel;
    logic signed [SAMPLE_BITS-1:0] y2_sel;
    logic signed [COEF_BITS-1:0]   b0_sel;
    logic signed [COEF_BITS-1:0]   a1_sel;
    logic signed [COEF_BITS-1:0]   a2_sel;

    // feed-forward sum: high-pass x + x2 - 2*x1, low-pass hp + m2 + 2*m1
    always_comb begin
        if (ctrl.ff_lp) begin
            ff_val = FF_BITS'(hp_reg) + FF_BITS'(hist.m2) + (FF_BITS'(hist.m1) <<< 1);
        end else begin
            ff_val = FF_BITS'(x_reg) + FF_BITS'(hist.x2) - (FF_BITS'(hist.x1) <<< 1);
        end
    end

    always_comb begin
        y1_sel = ctrl.coef_lp ? hist.l1 : hist.m1;
        y2_sel = ctrl.coef_lp ? hist.l2 : hist.m2;
        b0_sel = ctrl.coef_lp ? cfg.lp_b0 : cfg.hp_b0;
        a1_sel = ctrl.coef_lp ? cfg.lp_a1 : cfg.hp_a1;
        a2_sel = ctrl.coef_lp ? cfg.lp_a2 : cfg.hp_a2;
        case (ctrl.mul_sel)
            MUL_B0: begin
                mul_a = ff_reg;
                mul_b = MUL_B_BITS'(b0_sel);
            end
            MUL_A1: begin
                mul_a = MUL_A_BITS'(y1_sel);
                mul_b = MUL_B_BITS'(a1_sel);
            end
            MUL_A2: begin
                mul_a = MUL_A_BITS'(y2_sel);
                mul_b = MUL_B_BITS'(a2_sel);
            end
            MUL_GAIN: begin
                mul_a = MUL_A_BITS'(lp_reg);
                mul_b = MUL_B_BITS'({1'b0, cfg.gain});
            end
            default: begin
                mul_a = ff_reg;
                mul_b = MUL_B_BITS'(b0_sel);
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            x_reg    <= sample_in;
            chan_reg <= channel_in;
        end
        if (ctrl.ff_load) begin
            ff_reg <= ff_val;
        end
        prod_reg <= mul_a * mul_b;

        case (ctrl.acc_op)
            ACC_LOAD: acc_reg <= ACC_BITS'(prod_reg);
            ACC_SUB:  acc_reg <= acc_reg - ACC_BITS'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase

        case (ctrl.hp_op)
            STG_PASS: hp_reg <= x_reg;
            STG_RND:  hp_reg <= round_sat(acc_reg, COEF_BITS - 2);
            default:  hp_reg <= hp_reg;
        endcase

        case (ctrl.lp_op)
            STG_PASS: lp_reg <= hp_reg;
            STG_RND:  lp_reg <= round_sat(acc_reg, COEF_BITS - 2);
            default:  lp_reg <= lp_reg;
        endcase

        case (ctrl.res_op)
            RES_ZERO: res_reg <= '0;
            RES_GAIN: res_reg <= round_sat(ACC_BITS'(prod_reg), GAIN_FRAC_BITS);
            default:  res_reg <= res_reg;
        endcase
    end

    assign result  = res_reg;
    assign channel = chan_reg;

    // shift each history pair by one place
    always_comb begin
        hist_wr.x1 = x_reg;
        hist_wr.x2 = hist.x1;
        hist_wr.m1 = hp_reg;
        hist_wr.m2 = hist.m1;
        hist_wr.l1 = lp_reg;
        hist_wr.l2 = hist.l1;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mbbg_seq.sv =====
// Sequencer that steps one sample through both biquads and the gain.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mbbg_seq import mbbg_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rstn,
    input  wire logic                   accept,
    input  wire logic                   chan_oor,
    input  wire logic                   out_free,
    input  wire logic [BYPASS_BITS-1:0] bypass,
    output ctrl_t                       ctrl,
    output seq_stat_t                   stat
);

    state_t state_reg;
    state_t state_next;
    logic   oor_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
            oor_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                oor_reg <= chan_oor;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (oor_reg) begin
                    state_next = ST_OUT;
                end else if (bypass[0]) begin
                    state_next = ST_LP_FF;
                end else begin
                    state_next = ST_HP_B;
                end
            end
            ST_HP_B:   state_next = ST_HP_A1;
            ST_HP_A1:  state_next = ST_HP_A2;
            ST_HP_A2:  state_next = ST_HP_SUM;
            ST_HP_SUM: state_next = ST_HP_RND;
            ST_HP_RND: state_next = ST_LP_FF;
            ST_LP_FF: begin
                state_next = bypass[1] ? ST_GAIN_M : ST_LP_B;
            end
            ST_LP_B:     state_next = ST_LP_A1;
            ST_LP_A1:    state_next = ST_LP_A2;
            ST_LP_A2:    state_next = ST_LP_SUM;
            ST_LP_SUM:   state_next = ST_LP_RND;
            ST_LP_RND:   state_next = ST_GAIN_M;
            ST_GAIN_M:   state_next = ST_GAIN_RND;
            ST_GAIN_RND: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.ff_load = 1'b0;
        ctrl.ff_lp   = 1'b0;
        ctrl.mul_sel = MUL_B0;
        ctrl.coef_lp = 1'b0;
        ctrl.acc_op  = ACC_HOLD;
        ctrl.hp_op   = STG_HOLD;
        ctrl.lp_op   = STG_HOLD;
        ctrl.res_op  = RES_HOLD;
        case (state_reg)
            ST_READ: begin
                ctrl.ff_load = 1'b1;
                ctrl.hp_op   = bypass[0] ? STG_PASS : STG_HOLD;
                ctrl.res_op  = oor_reg ? RES_ZERO : RES_HOLD;
            end
            ST_HP_B:  ctrl.mul_sel = MUL_B0;
            ST_HP_A1: begin
                ctrl.mul_sel = MUL_A1;
                ctrl.acc_op  = ACC_LOAD;
            end
            ST_HP_A2: begin
                ctrl.mul_sel = MUL_A2;
                ctrl.acc_op  = ACC_SUB;
            end
            ST_HP_SUM: ctrl.acc_op = ACC_SUB;
            ST_HP_RND: ctrl.hp_op  = STG_RND;
            ST_LP_FF: begin
                ctrl.ff_load = 1'b1;
                ctrl.ff_lp   = 1'b1;
                ctrl.lp_op   = bypass[1] ? STG_PASS : STG_HOLD;
            end
            ST_LP_B: begin
                ctrl.mul_sel = MUL_B0;
                ctrl.coef_lp = 1'b1;
            end
            ST_LP_A1: begin
                ctrl.mul_sel = MUL_A1;
                ctrl.coef_lp = 1'b1;
                ctrl.acc_op  = ACC_LOAD;
            end
            ST_LP_A2: begin
                ctrl.mul_sel = MUL_A2;
                ctrl.coef_lp = 1'b1;
                ctrl.acc_op  = ACC_SUB;
            end
            ST_LP_SUM:   ctrl.acc_op  = ACC_SUB;
            ST_LP_RND:   ctrl.lp_op   = STG_RND;
            ST_GAIN_M:   ctrl.mul_sel = MUL_GAIN;
            ST_GAIN_RND: ctrl.res_op  = RES_GAIN;
            default: ;
        endcase
    end

    always_comb begin
        stat.idle     = (state_reg == ST_IDLE);
        stat.out_load = (state_reg == ST_OUT) && out_free;
        stat.hist_we  = (state_reg == ST_OUT) && out_free && !oor_reg;
    end

    `ASSERT_NEXT(a_accept_reads, clk, rstn, accept, state_reg == ST_READ)
    `ASSERT_NEXT(a_oor_skips, clk, rstn, (state_reg == ST_READ) && oor_reg, state_reg == ST_OUT)

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_bandpass_biquad_gain_core.sv =====
// Top level of the multichannel band-pass biquad filter with output gain.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Each sample with its channel number passes through a high-pass biquad, a
// low-pass biquad (both direct form 1, b2 = b0, b1 = -2*b0 or +2*b0) and a
// linear gain, with rounding (ties up) and 24-bit saturation after every stage.
// Per-channel history sits in one memory entry per channel; valid bits make a
// cleared entry read as zero, so reset and coefficient writes take effect at
// once with no clearing pass. A channel number at or above the channel count
// returns zero and leaves history alone. Bit 0 of the bypass field passes the
// high-pass stage through, bit 1 the low-pass stage; history still advances.
// Samples are taken one at a time: a new input transfer is accepted only
// once the sequencer is back in idle. A bypassed stage skips its multiply,
// sum and rounding states, and an out-of-range channel goes straight from
// the read state to the output state. One shared multiplier forms the three
// products of each biquad and the gain product in turn; each sample also
// needs one memory read and one write back. A finished result waits in the
// output register, so the next input transfer can start while the downstream
// side stalls. Write configuration only while no sample is in flight.

module multichannel_bandpass_biquad_gain_core import mbbg_pkg::*; (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    // input sample channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  wire logic [CHAN_BITS-1:0]          s_channel_in,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    output logic [CHAN_BITS-1:0]               m_channel_out
);

    cfg_t                          cfg_reg;
    cfg_t                          cfg_next;
    logic                          coef_clear;

    logic                          s_accept;
    logic                          chan_oor;
    logic                          out_free;

    ctrl_t                         ctrl;
    seq_stat_t                     stat;
    hist_t                         hist_rd;
    hist_t                         hist_wr;
    logic signed [SAMPLE_BITS-1:0] dp_result;
    logic [CHAN_BITS-1:0]          dp_channel;

    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;
    logic [CHAN_BITS-1:0]          m_channel_reg;

    // ---------------------------------------------------------------
    // Configuration registers; any coefficient write drops all history
    // ---------------------------------------------------------------
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_HP_B0:  cfg_next.hp_b0  = cfg_wdata[COEF_BITS-1:0];
                CFG_HP_A1:  cfg_next.hp_a1  = cfg_wdata[COEF_BITS-1:0];
                CFG_HP_A2:  cfg_next.hp_a2  = cfg_wdata[COEF_BITS-1:0];
                CFG_LP_B0:  cfg_next.lp_b0  = cfg_wdata[COEF_BITS-1:0];
                CFG_LP_A1:  cfg_next.lp_a1  = cfg_wdata[COEF_BITS-1:0];
                CFG_LP_A2:  cfg_next.lp_a2  = cfg_wdata[COEF_BITS-1:0];
                CFG_GAIN:   cfg_next.gain   = cfg_wdata[GAIN_BITS-1:0];
                CFG_BYPASS: cfg_next.bypass = cfg_wdata[BYPASS_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign coef_clear = cfg_we && (cfg_index inside {CFG_HP_B0, CFG_HP_A1, CFG_HP_A2,
                                                     CFG_LP_B0, CFG_LP_A1, CFG_LP_A2});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hp_b0  <= '0;
            cfg_reg.hp_a1  <= '0;
            cfg_reg.hp_a2  <= '0;
            cfg_reg.lp_b0  <= '0;
            cfg_reg.lp_a1  <= '0;
            cfg_reg.lp_a2  <= '0;
            cfg_reg.gain   <= GAIN_UNITY;
            cfg_reg.bypass <= BYPASS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Input side: take a transfer only when the sequencer is idle
    // ---------------------------------------------------------------
    assign s_ready  = stat.idle;
    assign s_accept = s_valid && s_ready;
    assign chan_oor = (int'(s_channel_in) >= CHANNEL_COUNT);
    assign out_free = !m_valid_reg || m_ready;

    mbbg_seq u_seq (
        .clk      (aclk),
        .rstn     (aresetn),
        .accept   (s_accept),
        .chan_oor (chan_oor),
        .out_free (out_free),
        .bypass   (cfg_reg.bypass),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    // Read the channel's history on the input transfer, write it back when
    // the result moves to the output register.
    mbbg_hist_mem u_hist_mem (
        .clk     (aclk),
        .rstn    (aresetn),
        .clear   (coef_clear),
        .rd_en   (s_accept && !chan_oor),
        .rd_addr (CH_IDX_BITS'(s_channel_in)),
        .rd_data (hist_rd),
        .wr_en   (stat.hist_we),
        .wr_addr (CH_IDX_BITS'(dp_channel)),
        .wr_data (hist_wr)
    );

    mbbg_dp u_dp (
        .clk        (aclk),
        .accept     (s_accept),
        .sample_in  (s_sample_in),
        .channel_in (s_channel_in),
        .ctrl       (ctrl),
        .cfg        (cfg_reg),
        .hist       (hist_rd),
        .result     (dp_result),
        .channel    (dp_channel),
        .hist_wr    (hist_wr)
    );

    // ---------------------------------------------------------------
    // Output register: hold the result until the transfer completes
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.out_load) begin
            m_sample_reg  <= dp_result;
            m_channel_reg <= dp_channel;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_out  = m_sample_reg;
    assign m_channel_out = m_channel_reg;

    `ASSERT_AT(a_out_no_overwrite, aclk, aresetn, stat.out_load |-> (!m_valid_reg || m_ready))
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_ready)

endmodule

`default_nettype wire
